FILE: rtl/core/sts_pkg.sv
// Shared types and constants of the software timer scheduler.
`default_nettype none

package sts_pkg;

  // Field widths of the stream payloads
  localparam int IdW     = 4;
  localparam int TimeW   = 32;
  localparam int StatusW = 2;
  localparam int InDataW  = 72;
  localparam int OutDataW = 40;

  // Result status codes
  localparam logic [StatusW-1:0] StFired = 2'd0;
  localparam logic [StatusW-1:0] StAdded = 2'd1;
  localparam logic [StatusW-1:0] StIdle  = 2'd2;

  // Input kinds carried in tuser
  localparam logic OpTick = 1'b0;
  localparam logic OpAdd  = 1'b1;

  // One timer table entry
  typedef struct packed {
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] reload;
    logic             cyclic;
  } entry_t;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RSP,
    ST_MARK,
    ST_SEL,
    ST_FIRE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/software_timer_scheduler_top.sv
// Software timer scheduler: sequencer, timer table and shared arithmetic unit.
//
// Channel   Dir  Signals                      Content
// s_axis    in   tvalid tready tdata tuser    add timer or tick transaction
// m_axis    out  tvalid tready tdata tlast    one result per fired timer, or one status
//
// A tick makes one table pass that marks due slots, and one pass per fired timer
// that picks the earliest (one pass when nothing is due), all through the single
// table read port and the shared adder. Reset clears the tick count, valid bits
// and control; the table itself is not cleared. A stalled result holds in the
// output register and the sequencer waits for it.
`default_nettype none

module software_timer_scheduler_top #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [3:0] timer_id, [35:4] first_due, [67:36] period_ticks, [68] repeat_mode
  input  logic [sts_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] opcode
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [5:2] fired_id, [37:6] tick_now
  output logic [sts_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CntW = $clog2(NUM_TIMERS + 1);
  localparam logic [CntW-1:0] CntEnd = CntW'(NUM_TIMERS);

  // Input field unpacking
  logic [sts_pkg::IdW-1:0]   in_id;
  logic [sts_pkg::TimeW-1:0] in_first;
  logic [sts_pkg::TimeW-1:0] in_period;
  logic                      in_mode;

  assign in_id     = s_axis_tdata_i[3:0];
  assign in_first  = s_axis_tdata_i[35:4];
  assign in_period = s_axis_tdata_i[67:36];
  assign in_mode   = s_axis_tdata_i[68];

  // State
  sts_pkg::state_e           state_q, state_d;
  logic [sts_pkg::TimeW-1:0] tick_q, tick_d;
  logic [NUM_TIMERS-1:0]     valid_q, valid_d;
  logic [NUM_TIMERS-1:0]     pend_q, pend_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      lag_vld_q, lag_vld_d;
  logic [IdxW-1:0]           lag_idx_q, lag_idx_d;
  logic                      found_q, found_d;
  logic [IdxW-1:0]           best_idx_q, best_idx_d;
  sts_pkg::entry_t           best_q, best_d;

  // Output register
  logic                       out_vld_q, out_vld_d;
  logic [sts_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [sts_pkg::IdW-1:0]    out_id_q, out_id_d;
  logic [sts_pkg::TimeW-1:0]  out_tick_q, out_tick_d;
  logic                       out_last_q, out_last_d;
  logic                       out_free;

  // Shared unit and table ports
  sts_pkg::alu_op_e          alu_op;
  logic [sts_pkg::TimeW-1:0] alu_a, alu_b, alu_res;
  logic                      alu_lt;
  logic                      wr_en;
  logic [IdxW-1:0]           wr_idx;
  sts_pkg::entry_t           wr_data;
  sts_pkg::entry_t           rd_data;
  logic [NUM_TIMERS-1:0]     pend_rest;

  assign out_free = ~out_vld_q | m_axis_tready_i;

  sts_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  sts_table #(
    .Depth (NUM_TIMERS),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_idx_i  (cnt_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // Pending set once the chosen timer is taken out
  always_comb begin
    pend_rest             = pend_q;
    pend_rest[best_idx_q] = 1'b0;
  end

  // Sequencer: next state, unit operands, table writes, results
  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    valid_d      = valid_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    lag_vld_d    = 1'b0;
    lag_idx_d    = cnt_q[IdxW-1:0];
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    alu_op       = sts_pkg::ALU_ADD;
    alu_a        = tick_q;
    alu_b        = {{(sts_pkg::TimeW-1){1'b0}}, 1'b1};
    wr_en        = 1'b0;
    wr_idx       = best_idx_q;
    wr_data      = best_q;
    out_vld_d    = out_vld_q & ~m_axis_tready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_tick_d   = out_tick_q;
    out_last_d   = out_last_q;
    s_axis_tready_o = 1'b0;

    case (state_q)
      sts_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == sts_pkg::OpAdd) begin
            // Ids past the table are acknowledged but not stored
            if (32'(in_id) < 32'(NUM_TIMERS)) begin
              wr_en          = 1'b1;
              wr_idx         = IdxW'(in_id);
              wr_data.due    = in_first;
              wr_data.reload = in_period;
              wr_data.cyclic = in_mode;
              valid_d[IdxW'(in_id)] = 1'b1;
            end
            state_d = sts_pkg::ST_ADD_RSP;
          end else begin
            tick_d  = alu_res;
            cnt_d   = '0;
            state_d = sts_pkg::ST_MARK;
          end
        end
      end

      sts_pkg::ST_ADD_RSP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = sts_pkg::StAdded;
          out_id_d     = '0;
          out_tick_d   = tick_q;
          out_last_d   = 1'b1;
          state_d      = sts_pkg::ST_IDLE;
        end
      end

      // Pass over the table: flag every valid slot due at the new count
      sts_pkg::ST_MARK: begin
        if (cnt_q != CntEnd) begin
          lag_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        if (lag_vld_q) begin
          alu_op = sts_pkg::ALU_SUB;
          alu_a  = tick_q;
          alu_b  = rd_data.due;
          pend_d[lag_idx_q] = valid_q[lag_idx_q] & ~alu_lt;
        end
        if (cnt_q == CntEnd) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = sts_pkg::ST_SEL;
        end
      end

      // Pass over the table: earliest pending due time, lower id on ties
      sts_pkg::ST_SEL: begin
        if (cnt_q != CntEnd) begin
          lag_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        if (lag_vld_q && pend_q[lag_idx_q]) begin
          alu_op = sts_pkg::ALU_SUB;
          alu_a  = rd_data.due;
          alu_b  = best_q.due;
          if (!found_q || alu_lt) begin
            best_d     = rd_data;
            best_idx_d = lag_idx_q;
            found_d    = 1'b1;
          end
        end
        if (cnt_q == CntEnd) begin
          state_d = sts_pkg::ST_FIRE;
        end
      end

      // Emit the chosen timer and re-arm or free it, or the idle status when none is due
      sts_pkg::ST_FIRE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_tick_d = tick_q;
          if (!found_q) begin
            out_status_d = sts_pkg::StIdle;
            out_id_d     = '0;
            out_last_d   = 1'b1;
            state_d      = sts_pkg::ST_IDLE;
          end else begin
            out_status_d = sts_pkg::StFired;
            out_id_d     = sts_pkg::IdW'(best_idx_q);
            out_last_d   = ~|pend_rest;
            pend_d       = pend_rest;
            if (best_q.cyclic) begin
              alu_op      = sts_pkg::ALU_ADD;
              alu_a       = best_q.due;
              alu_b       = best_q.reload;
              wr_en       = 1'b1;
              wr_data.due = alu_res;
            end else begin
              valid_d[best_idx_q] = 1'b0;
            end
            cnt_d   = '0;
            found_d = 1'b0;
            state_d = (~|pend_rest) ? sts_pkg::ST_IDLE : sts_pkg::ST_SEL;
          end
        end
      end

      default: begin
        state_d = sts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sts_pkg::ST_IDLE;
      tick_q    <= '0;
      valid_q   <= '0;
      pend_q    <= '0;
      cnt_q     <= '0;
      lag_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      valid_q   <= valid_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      lag_vld_q <= lag_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lag_idx_q    <= lag_idx_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_tick_q   <= out_tick_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_tick_q, out_id_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/sts_alu.sv
// Shared 32-bit add / subtract-compare unit.
`default_nettype none

module sts_alu (
  input  sts_pkg::alu_op_e              op_i,
  input  logic [sts_pkg::TimeW-1:0]     a_i,
  input  logic [sts_pkg::TimeW-1:0]     b_i,
  output logic [sts_pkg::TimeW-1:0]     res_o,
  output logic                          lt_o
);

  logic [sts_pkg::TimeW-1:0] b_op;
  logic                      cin;
  logic [sts_pkg::TimeW:0]   sum;

  // Subtract is a plus inverted b plus one; carry out clear means a < b
  assign b_op  = (op_i == sts_pkg::ALU_SUB) ? ~b_i : b_i;
  assign cin   = (op_i == sts_pkg::ALU_SUB);
  assign sum   = {1'b0, a_i} + {1'b0, b_op} + {{sts_pkg::TimeW{1'b0}}, cin};
  assign res_o = sum[sts_pkg::TimeW-1:0];
  assign lt_o  = ~sum[sts_pkg::TimeW];

endmodule

`default_nettype wire

FILE: rtl/core/sts_table.sv
// Timer table memory: one write port, one registered read port.
`default_nettype none

module sts_table #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  sts_pkg::entry_t     wr_data_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output sts_pkg::entry_t     rd_data_o
);

  sts_pkg::entry_t mem [Depth];
  sts_pkg::entry_t rd_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_q <= mem[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/core/sts_checker.sv
// Port-level checks of the software timer scheduler, bound to the top level.
`default_nettype none

module sts_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_o,
  input  logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic [sts_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           m_axis_tlast_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // The block is busy in the cycle after taking a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after an accepted transaction");

  // Add and idle-tick results stand alone and carry no id
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == sts_pkg::StAdded ||
                        m_axis_tdata_o[1:0] == sts_pkg::StIdle) |->
      m_axis_tlast_o && m_axis_tdata_o[5:2] == 4'd0)
    else $error("status result not final or with nonzero id");

  // Only fired timers can be followed by more results of the same tick
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[1:0] == sts_pkg::StFired)
    else $error("non-final result is not a fired timer");

endmodule

bind software_timer_scheduler_top sts_checker u_sts_checker (.*);

`default_nettype wire

FILE: tb/timer_board_pkg.sv
// Scoreboard for the timer scheduler testbench: fire-order predictor and result checker.
`timescale 1ns / 1ps

package timer_board_pkg;
  import sts_pkg::*;

  localparam int NumSlots = 16;

  // One result transaction as seen on the output stream
  typedef struct {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     fired_id;
    logic [TimeW-1:0]   tick_now;
    logic               last;
  } sched_rsp_t;

  class timer_board;
    logic [TimeW-1:0] tick_cnt;
    logic [TimeW-1:0] due_at [NumSlots];
    logic [TimeW-1:0] reload [NumSlots];
    logic             cyclic [NumSlots];
    logic             armed  [NumSlots];
    sched_rsp_t       owed_results [$];
    int unsigned      failures;

    function new();
      tick_cnt = '0;
      failures = 0;
      foreach (armed[i]) armed[i] = 1'b0;
    endfunction

    // Work out the results that one accepted input transaction produces
    function void note_request(logic op, logic [IdW-1:0] id, logic [TimeW-1:0] first_due,
                               logic [TimeW-1:0] period, logic repeat_mode);
      logic       due_now [NumSlots];
      sched_rsp_t rsp;
      int         best;
      int         fired;
      rsp.fired_id = '0;
      if (op == OpAdd) begin
        // the table has 16 slots, so every 4-bit id lands in it
        due_at[id] = first_due;
        reload[id] = period;
        cyclic[id] = repeat_mode;
        armed[id]  = 1'b1;
        rsp.status   = StAdded;
        rsp.tick_now = tick_cnt;
        rsp.last     = 1'b1;
        owed_results.push_back(rsp);
        return;
      end
      tick_cnt = tick_cnt + 1'b1;
      // snapshot of due slots; re-armed timers are not looked at again this tick
      foreach (due_now[i]) due_now[i] = armed[i] && (due_at[i] <= tick_cnt);
      fired = 0;
      while (1) begin
        best = -1;
        // earliest due first, lower id wins a tie
        foreach (due_now[i]) begin
          if (due_now[i] && (best < 0 || due_at[i] < due_at[best])) best = i;
        end
        if (best < 0) break;
        due_now[best] = 1'b0;
        rsp.status   = StFired;
        rsp.fired_id = IdW'(best);
        rsp.tick_now = tick_cnt;
        rsp.last     = 1'b0;
        owed_results.push_back(rsp);
        fired++;
        if (cyclic[best]) due_at[best] = due_at[best] + reload[best];
        else armed[best] = 1'b0;
      end
      if (fired == 0) begin
        rsp.status   = StIdle;
        rsp.fired_id = '0;
        rsp.tick_now = tick_cnt;
        rsp.last     = 1'b1;
        owed_results.push_back(rsp);
      end else begin
        rsp = owed_results.pop_back();
        rsp.last = 1'b1;
        owed_results.push_back(rsp);
      end
    endfunction

    // Compare one output transaction with the oldest outstanding result
    function void check_result(logic [OutDataW-1:0] data, logic lst);
      sched_rsp_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing outstanding: tdata=%h tlast=%b", data, lst);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (data[StatusW-1:0] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[StatusW-1:0]);
        failures++;
      end
      if (data[StatusW +: IdW] !== want.fired_id) begin
        $error("fired_id: expected %0d, got %0d", want.fired_id, data[StatusW +: IdW]);
        failures++;
      end
      if (data[StatusW+IdW +: TimeW] !== want.tick_now) begin
        $error("tick_now: expected %0d, got %0d", want.tick_now, data[StatusW+IdW +: TimeW]);
        failures++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, lst);
        failures++;
      end
    endfunction

    // Anything still owed at the end is a failure
    function void flush_check();
      if (owed_results.size() != 0) begin
        $error("%0d results never arrived", owed_results.size());
        failures++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench of the software timer scheduler: stimulus, handshakes and run control.
`timescale 1ns / 1ps

module tb;
  import sts_pkg::*;
  import timer_board_pkg::*;

  localparam int RandomItems = 390;
  localparam int QuietTail   = 60;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 400;
  localparam logic [TimeW-1:0] TimeMax = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  timer_board board;
  bit         no_idle     = 1'b0;
  bit         rx_hold_req = 1'b0;
  int         quiet_cycles = 0;

  software_timer_scheduler_top #(
    .NUM_TIMERS(NumSlots)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one transaction and hold it until the block takes it
  task automatic send_item(logic op, logic [IdW-1:0] id, logic [TimeW-1:0] first_due,
                           logic [TimeW-1:0] period, logic repeat_mode);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, repeat_mode, period, first_due, id};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, id, first_due, period, repeat_mode);
  endtask

  // Random idle burst on the input side
  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Stop sending until every owed result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.owed_results.size() != 0);
  endtask

  // Mostly near-term due times and short periods so that timers actually fire
  task automatic send_random();
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] first_due;
    logic [TimeW-1:0] period;
    int               pick;
    if ($urandom_range(0, 99) < 55) begin
      // tick: payload is don't-care, keep it random
      send_item(OpTick, IdW'($urandom), $urandom, $urandom, 1'($urandom));
    end else begin
      id   = IdW'($urandom_range(0, NumSlots - 1));
      pick = $urandom_range(0, 99);
      if (pick < 60)      first_due = board.tick_cnt + $urandom_range(0, 6);
      else if (pick < 75) first_due = $urandom_range(0, board.tick_cnt);
      else if (pick < 90) first_due = $urandom;
      else                first_due = ($urandom_range(0, 1) != 0) ? TimeMax : '0;
      pick = $urandom_range(0, 99);
      if (pick < 60)      period = $urandom_range(1, 8);
      else if (pick < 80) period = $urandom;
      else if (pick < 92) period = TimeMax;
      else if (pick < 96) period = '0;
      else                period = $urandom_range(9, 64);
      send_item(OpAdd, id, first_due, period, 1'($urandom));
    end
  endtask

  // Hand-picked cases: extremes, replacement, ties, wrap on re-arm, zero interval
  task automatic run_directed();
    sender_gap(); send_item(OpTick, 4'hF, TimeMax, TimeMax, 1'b1);
    sender_gap(); send_item(OpAdd, 4'd0, '0, TimeMax, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd15, TimeMax, 32'd1, 1'b1);
    sender_gap(); send_item(OpAdd, 4'd3, 32'd2, TimeMax, 1'b1);
    sender_gap(); send_item(OpAdd, 4'd5, 32'd2, '0, 1'b1);
    sender_gap(); send_item(OpAdd, 4'd7, 32'd2, 32'd1, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd7, 32'd3, 32'd2, 1'b1);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
    sender_gap(); send_item(OpTick, 4'hA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd2, 32'd5, 32'd1, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd1, 32'd5, 32'h8000_0000, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd4, '0, 32'd1, 1'b1);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd5, TimeMax, '0, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd10, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    sender_gap(); send_item(OpAdd, 4'd4, 32'd8, 32'h7FFF_FFFF, 1'b1);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
    sender_gap(); send_item(OpTick, '0, '0, '0, 1'b0);
  endtask

  // Output side: ready bursts, idle bursts and one long hold-off on request
  initial begin
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Main sequence
  initial begin
    board = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpTick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_directed();
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - QuietTail) no_idle = 1'b1;
      if (n == 120) rx_hold_req = 1'b1;
      if (n == 250) wait_drained();
      sender_gap();
      send_random();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    board.flush_check();
    if (board.failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sts_pkg.sv
rtl/core/sts_alu.sv
rtl/core/sts_table.sv
rtl/core/software_timer_scheduler_top.sv
rtl/core/sts_checker.sv
tb/timer_board_pkg.sv
tb/tb.sv
